// File: rtl/core/interval_timer_square_wave_channel_unit_macros.svh
// assertion macros for the timer channel logic in itsw_channel.sv
`ifndef INTERVAL_TIMER_SQUARE_WAVE_CHANNEL_UNIT_MACROS_SVH
`define INTERVAL_TIMER_SQUARE_WAVE_CHANNEL_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ITSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ITSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/itsw_pkg.sv
// types and constants for the interval timer square-wave channel
package itsw_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_CTRL  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        out_level;
        logic        irq_pulse;
    } t_out_word;

    localparam logic [7:0]  CTRL_MODE_MASK  = 8'hF7;
    localparam logic [7:0]  CTRL_MODE3      = 8'h36;
    localparam logic [7:0]  CTRL_LATCH_MASK = 8'hF0;
    localparam logic [7:0]  CTRL_LATCH      = 8'h00;
    localparam logic [16:0] COUNT_FULL      = 17'h10000;

endpackage

// File: rtl/core/itsw_channel.sv
// channel state and single-pass item logic of the square-wave timer
`include "interval_timer_square_wave_channel_unit_macros.svh"

module itsw_channel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  itsw_pkg::t_in_word  i_word,
    output itsw_pkg::t_out_word o_result
);
    import itsw_pkg::*;

    logic [15:0] r_reload, n_reload;
    logic [15:0] r_live, n_live;
    logic [15:0] r_latched, n_latched;
    logic        r_latch_held, n_latch_held;
    logic        r_write_high, n_write_high;
    logic        r_read_high, n_read_high;
    logic        r_wave, n_wave;
    logic        r_running, n_running;

    logic [16:0] cur;
    logic [16:0] dec;
    logic [16:0] cur_less;
    logic [15:0] rd_src;
    logic [15:0] reload_hi;
    logic [7:0]  rd_byte;
    logic        irq;

    always_comb begin
        n_reload     = r_reload;
        n_live       = r_live;
        n_latched    = r_latched;
        n_latch_held = r_latch_held;
        n_write_high = r_write_high;
        n_read_high  = r_read_high;
        n_wave       = r_wave;
        n_running    = r_running;
        rd_byte      = 8'd0;
        irq          = 1'b0;

        // zero count stands for 65536
        cur = (r_live == 16'd0) ? COUNT_FULL : {1'b0, r_live};
        if (cur[0]) begin
            dec = r_wave ? 17'd1 : 17'd3;
        end else begin
            dec = 17'd2;
        end
        cur_less  = cur - dec;
        rd_src    = r_latch_held ? r_latched : r_live;
        reload_hi = {i_word.data_byte, r_reload[7:0]};

        case (i_word.kind)
            KIND_TICK: begin
                if (r_running) begin
                    if (cur <= dec) begin
                        n_wave = ~r_wave;
                        irq    = ~r_wave;
                        n_live = r_reload;
                    end else begin
                        n_live = cur_less[15:0];
                    end
                end
            end
            KIND_CTRL: begin
                if ((i_word.data_byte & CTRL_MODE_MASK) == CTRL_MODE3) begin
                    n_running    = 1'b0;
                    n_wave       = 1'b1;
                    n_latch_held = 1'b0;
                    n_write_high = 1'b0;
                    n_read_high  = 1'b0;
                end else if ((i_word.data_byte & CTRL_LATCH_MASK) == CTRL_LATCH) begin
                    if (!r_latch_held) begin
                        n_latched    = r_live;
                        n_latch_held = 1'b1;
                    end
                end
            end
            KIND_WRITE: begin
                if (!r_write_high) begin
                    n_reload     = {r_reload[15:8], i_word.data_byte};
                    n_write_high = 1'b1;
                end else begin
                    n_reload     = reload_hi;
                    n_write_high = 1'b0;
                    if (!r_running) begin
                        n_live    = reload_hi;
                        n_running = 1'b1;
                    end
                end
            end
            KIND_READ: begin
                if (!r_read_high) begin
                    rd_byte     = rd_src[7:0];
                    n_read_high = 1'b1;
                end else begin
                    rd_byte      = rd_src[15:8];
                    n_read_high  = 1'b0;
                    n_latch_held = 1'b0;
                end
            end
            default: begin
            end
        endcase

        o_result.read_byte = rd_byte;
        o_result.out_level = n_wave;
        o_result.irq_pulse = irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload     <= 16'd0;
            r_live       <= 16'd0;
            r_latched    <= 16'd0;
            r_latch_held <= 1'b0;
            r_write_high <= 1'b0;
            r_read_high  <= 1'b0;
            r_wave       <= 1'b1;
            r_running    <= 1'b0;
        end else if (i_fire) begin
            r_reload     <= n_reload;
            r_live       <= n_live;
            r_latched    <= n_latched;
            r_latch_held <= n_latch_held;
            r_write_high <= n_write_high;
            r_read_high  <= n_read_high;
            r_wave       <= n_wave;
            r_running    <= n_running;
        end
    end

    `ITSW_ASSERT_NOW(a_irq_means_high, i_fire && o_result.irq_pulse,
        o_result.out_level && !r_wave, "irq pulse without a rising output")
    `ITSW_ASSERT_NOW(a_irq_only_tick, i_fire && (i_word.kind != KIND_TICK),
        !o_result.irq_pulse, "irq pulse on a non-tick word")
    `ITSW_ASSERT_NOW(a_byte_only_read, i_fire && (i_word.kind != KIND_READ),
        o_result.read_byte == 8'd0, "read byte nonzero on a non-read word")
    `ITSW_ASSERT_NEXT(a_mode_set_stops,
        i_fire && (i_word.kind == KIND_CTRL)
            && ((i_word.data_byte & CTRL_MODE_MASK) == CTRL_MODE3),
        !r_running && r_wave && !r_latch_held && !r_write_high && !r_read_high,
        "mode set did not stop the channel")
    `ITSW_ASSERT_NEXT(a_stopped_tick_holds,
        i_fire && (i_word.kind == KIND_TICK) && !r_running,
        $stable(r_live) && $stable(r_wave), "tick changed a stopped channel")

endmodule

// File: rtl/core/interval_timer_square_wave_channel_unit.sv
// top level of the interval timer square-wave channel with word handshakes
//
//   channel   direction   handshake                payload
//   in        input       i_in_valid / o_in_ready  i_in_word  (kind, data_byte)
//   out       output      o_out_valid / i_out_ready o_out_word (read_byte, out_level, irq_pulse)
//
// one word accepted per cycle while o_in_ready is high; each word gives one result word
// the pipeline is one input register plus one result register around the channel logic
// synchronous active-low reset clears the valid flags of both stages and the channel state
// a stalled result register holds the input stage, which then drops o_in_ready

module interval_timer_square_wave_channel_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itsw_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output itsw_pkg::t_out_word o_out_word
);
    import itsw_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      advance;

    // the held word moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    itsw_channel u_channel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: verif/interval_timer_square_wave_channel_unit_test.sv
// self-checking testbench for the interval timer square-wave channel unit
module interval_timer_square_wave_channel_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import itsw_pkg::*;

    typedef struct {
        t_in_word word;
        bit       drain;
    } t_pending;

    logic      clk;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word  = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    t_pending  pend_q[$];
    t_out_word level_q[$];

    // predicted channel state
    logic [15:0] tmr_reload, tmr_live, tmr_latched;
    logic        tmr_latch_held, tmr_wr_hi, tmr_rd_hi, tmr_level, tmr_running;

    int fails, words_in, words_out, irq_seen, drains_done;
    int gap_left, stall_left;
    bit long_hold_done;

    interval_timer_square_wave_channel_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic t_out_word predict_channel(t_in_word w);
        t_out_word   r;
        logic [16:0] cur, dec;
        logic [15:0] v;
        r = '0;
        case (w.kind)
            KIND_TICK: begin
                if (tmr_running) begin
                    cur = (tmr_live == 16'd0) ? COUNT_FULL : {1'b0, tmr_live};
                    // odd counts spend the extra tick in the high half
                    if (cur[0])
                        dec = tmr_level ? 17'd1 : 17'd3;
                    else
                        dec = 17'd2;
                    if (cur <= dec) begin
                        tmr_level   = !tmr_level;
                        r.irq_pulse = tmr_level;
                        tmr_live    = tmr_reload;
                    end else begin
                        cur      = cur - dec;
                        tmr_live = cur[15:0];
                    end
                end
            end
            KIND_CTRL: begin
                if ((w.data_byte & CTRL_MODE_MASK) == CTRL_MODE3) begin
                    tmr_running    = 1'b0;
                    tmr_level      = 1'b1;
                    tmr_latch_held = 1'b0;
                    tmr_wr_hi      = 1'b0;
                    tmr_rd_hi      = 1'b0;
                end else if ((w.data_byte & CTRL_LATCH_MASK) == CTRL_LATCH) begin
                    if (!tmr_latch_held) begin
                        tmr_latched    = tmr_live;
                        tmr_latch_held = 1'b1;
                    end
                end
            end
            KIND_WRITE: begin
                if (!tmr_wr_hi) begin
                    tmr_reload[7:0] = w.data_byte;
                    tmr_wr_hi       = 1'b1;
                end else begin
                    tmr_reload[15:8] = w.data_byte;
                    tmr_wr_hi        = 1'b0;
                    if (!tmr_running) begin
                        tmr_live    = tmr_reload;
                        tmr_running = 1'b1;
                    end
                end
            end
            default: begin
                v = tmr_latch_held ? tmr_latched : tmr_live;
                if (!tmr_rd_hi) begin
                    r.read_byte = v[7:0];
                    tmr_rd_hi   = 1'b1;
                end else begin
                    r.read_byte    = v[15:8];
                    tmr_rd_hi      = 1'b0;
                    tmr_latch_held = 1'b0;
                end
            end
        endcase
        r.out_level = tmr_level;
        return r;
    endfunction

    // no idling near the end, and every third stretch of 250 words runs flat out
    function automatic bit idling_allowed();
        return pend_q.size() >= 100 && ((words_in / 250) % 3) != 2;
    endfunction

    task automatic add_word(t_kind k, logic [7:0] b, bit drain = 1'b0);
        t_pending p;
        p.word.kind      = k;
        p.word.data_byte = b;
        p.drain          = drain;
        pend_q.push_back(p);
    endtask

    // sender
    always @(posedge clk) begin : drive
        logic     nxt_valid;
        t_in_word nxt_word;
        t_pending p;
        nxt_valid = in_valid;
        nxt_word  = in_word;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            gap_left  = 0;
        end else begin
            if (in_valid && in_ready) begin
                level_q.push_back(predict_channel(in_word));
                words_in++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0) begin
                    if (pend_q[0].drain && (level_q.size() != 0 || in_valid)) begin
                        // hold back until every outstanding word has come back
                    end else if (!pend_q[0].drain && idling_allowed()
                                 && $urandom_range(0, 15) == 0) begin
                        gap_left = $urandom_range(0, 15);
                    end else begin
                        p = pend_q.pop_front();
                        if (p.drain)
                            drains_done++;
                        nxt_valid = 1'b1;
                        nxt_word  = p.word;
                    end
                end
            end
        end
        in_valid <= nxt_valid;
        in_word  <= nxt_word;
    end

    // receiver and checker
    always @(posedge clk) begin : observe
        t_out_word want;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                words_out++;
                if (level_q.size() == 0) begin
                    $error("result word %h arrived with nothing expected", out_word);
                    fails++;
                end else begin
                    want = level_q.pop_front();
                    if (out_word.read_byte !== want.read_byte) begin
                        $error("read_byte: expected %02h, got %02h",
                               want.read_byte, out_word.read_byte);
                        fails++;
                    end
                    if (out_word.out_level !== want.out_level) begin
                        $error("out_level: expected %0b, got %0b",
                               want.out_level, out_word.out_level);
                        fails++;
                    end
                    if (out_word.irq_pulse !== want.irq_pulse) begin
                        $error("irq_pulse: expected %0b, got %0b",
                               want.irq_pulse, out_word.irq_pulse);
                        fails++;
                    end
                    if (out_word.irq_pulse === 1'b1)
                        irq_seen++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!long_hold_done && words_in >= 500) begin
                // long hold-off so the pipeline fills and backs up the input
                long_hold_done = 1'b1;
                stall_left     = 199;
                out_ready      <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : run
        int          n, body, r, i;
        logic [15:0] cnt;
        bit          drain_a, drain_b;

        tmr_reload     = '0;
        tmr_live       = '0;
        tmr_latched    = '0;
        tmr_latch_held = 1'b0;
        tmr_wr_hi      = 1'b0;
        tmr_rd_hi      = 1'b0;
        tmr_level      = 1'b1;
        tmr_running    = 1'b0;

        // count loaded straight after reset, odd count of five
        add_word(KIND_WRITE, 8'h05);
        add_word(KIND_WRITE, 8'h00);
        add_word(KIND_TICK, 8'hFF);
        add_word(KIND_TICK, 8'h00);
        add_word(KIND_TICK, 8'hA5);
        add_word(KIND_READ, 8'hFF);
        add_word(KIND_READ, 8'h00);
        // count of one: one tick high, one low
        add_word(KIND_CTRL, CTRL_MODE3);
        add_word(KIND_WRITE, 8'h01);
        add_word(KIND_WRITE, 8'h00);
        add_word(KIND_TICK, 8'h00);
        add_word(KIND_TICK, 8'h00);
        // latch, second latch ignored while held
        add_word(KIND_CTRL, 8'h0F);
        add_word(KIND_CTRL, 8'h00);
        add_word(KIND_TICK, 8'h00);
        add_word(KIND_READ, 8'h00);
        add_word(KIND_READ, 8'h00);
        // zero count stands for 65536
        add_word(KIND_CTRL, CTRL_MODE3 | 8'h08);
        add_word(KIND_WRITE, 8'h00);
        add_word(KIND_WRITE, 8'h00);
        add_word(KIND_TICK, 8'h00);
        add_word(KIND_READ, 8'h00);
        add_word(KIND_READ, 8'h00);
        // bcd, another channel and all ones are ignored
        add_word(KIND_CTRL, 8'h37);
        add_word(KIND_CTRL, 8'h76);
        add_word(KIND_CTRL, 8'hFF);

        drain_a = 1'b0;
        drain_b = 1'b0;
        while (pend_q.size() < 1320) begin
            if (!drain_a && pend_q.size() >= 400) begin
                drain_a = 1'b1;
                add_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
            end
            if (!drain_b && pend_q.size() >= 900) begin
                drain_b = 1'b1;
                add_word(KIND_READ, 8'($urandom_range(0, 255)), 1'b1);
            end
            if ($urandom_range(0, 99) < 75) begin
                add_word(KIND_CTRL, $urandom_range(0, 1) ? CTRL_MODE3 : (CTRL_MODE3 | 8'h08));
                if ($urandom_range(0, 7) == 0)
                    cnt = 16'($urandom_range(0, 65535));
                else
                    cnt = 16'($urandom_range(0, 24));
                add_word(KIND_WRITE, cnt[7:0]);
                add_word(KIND_WRITE, cnt[15:8]);
                body = $urandom_range(10, 40);
                for (i = 0; i < body; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        add_word(KIND_TICK, 8'($urandom_range(0, 255)));
                    else if (r < 75)
                        add_word(KIND_READ, 8'($urandom_range(0, 255)));
                    else if (r < 85)
                        add_word(KIND_CTRL, {4'h0, 4'($urandom_range(0, 15))});
                    else if (r < 95)
                        add_word(KIND_WRITE, $urandom_range(0, 3) == 0 ?
                                 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12)));
                    else
                        add_word(KIND_CTRL, 8'($urandom_range(0, 255)));
                end
            end else begin
                n = $urandom_range(5, 15);
                for (i = 0; i < n; i++)
                    add_word(t_kind'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid)
            @(posedge clk);
        for (i = 0; i < 5000 && level_q.size() != 0; i++)
            @(posedge clk);
        if (level_q.size() != 0) begin
            $error("%0d expected result words never arrived", level_q.size());
            fails++;
        end
        repeat (10) @(posedge clk);

        $display("summary: %0d words sent, %0d results checked, %0d interrupt pulses",
                 words_in, words_out, irq_seen);
        $display("summary: %0d drain pauses, long receiver hold-off %s",
                 drains_done, long_hold_done ? "done" : "missed");
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
